>>> src/tcp_transmit_control_unit_macros.svh
// ---------------------------------------------------------------------------
// tcp_transmit_control_unit_macros
// assertion helpers for the rtl of the transmit control unit
// ---------------------------------------------------------------------------
`ifndef TCP_TRANSMIT_CONTROL_UNIT_MACROS_SVH
`define TCP_TRANSMIT_CONTROL_UNIT_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define TCU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tcu_pkg.sv
// ---------------------------------------------------------------------------
// tcu_pkg
// types and constants of the tcp transmit control unit
// ---------------------------------------------------------------------------
package tcu_pkg;

    localparam int RESULT_LIMIT = 32;
    localparam int RES_AW       = 5;
    localparam int RES_NW       = 6;

    localparam logic [10:0] PAYLOAD_CEIL = 11'd1452;

    localparam logic [2:0] ACT_WRITE = 3'd0;
    localparam logic [2:0] ACT_END   = 3'd1;
    localparam logic [2:0] ACT_ACK   = 3'd2;
    localparam logic [2:0] ACT_TICK  = 3'd3;
    localparam logic [2:0] ACT_EMPTY = 3'd4;

    localparam logic [1:0] CFG_RTO  = 2'd0;
    localparam logic [1:0] CFG_ISEQ = 2'd1;
    localparam logic [1:0] CFG_MAXP = 2'd2;
    localparam logic [1:0] CFG_CAP  = 2'd3;

    // one outstanding segment in the retransmission queue
    typedef struct packed {
        logic [47:0] start;
        logic [10:0] len;
        logic        syn;
        logic        fin;
    } qent_t;

    // one segment descriptor waiting to go out
    typedef struct packed {
        logic [31:0] seqno;
        logic        syn;
        logic        fin;
        logic [47:0] offset;
        logic [10:0] len;
        logic        rexmit;
    } res_t;

    // write side of the result buffer
    typedef struct packed {
        logic              we;
        logic [RES_AW-1:0] waddr;
        res_t              wdata;
    } res_wr_t;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_ACKCHK  = 7'b0000010,
        S_ACKCMP  = 7'b0000100,
        S_POPCHK  = 7'b0001000,
        S_FILL    = 7'b0010000,
        S_TICKCHK = 7'b0100000,
        S_EMIT    = 7'b1000000
    } state_t;

endpackage

>>> src/tcp_transmit_control_unit.sv
// ---------------------------------------------------------------------------
// tcp_transmit_control_unit
// control side of a tcp sender: windowed segmentation, ack handling and
// retransmission timer, outstanding segments held in a queue memory
// ---------------------------------------------------------------------------
// One item at a time. The input is taken in the idle state; a write or end
// input then runs the window fill, one segment per cycle, which closes after
// a segment with fin or when no further segment fits. An ack is unwrapped
// and compared; an ack beyond the next sequence number goes straight to the
// output, any other pops the segments it covers, checking each head entry
// from the queue memory (whose read is registered) up to the first it does
// not cover, if any, and then runs the window fill; a tick checks the timer.
// The results then leave one per cycle, held under back pressure.
// ---------------------------------------------------------------------------
`include "tcp_transmit_control_unit_macros.svh"

module tcp_transmit_control_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    // configuration
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [31:0]   cfg_wdata,
    // input beats
    input  logic          s_tvalid,
    output logic          s_tready,
    // write_len[15:0], ack_number[47:16], peer_window[63:48], elapsed_ms[95:64]
    input  logic [95:0]   s_tdata,
    // action[2:0]
    input  logic [2:0]    s_tuser,
    // result beats
    output logic          m_tvalid,
    input  logic          m_tready,
    // seg_valid[0], seg_seqno[32:1], seg_syn[33], seg_fin[34],
    // payload_offset[82:35], payload_len[93:83], is_retransmit[94],
    // flight_bytes[111:95], retry_count[119:112], accepted_len[135:120]
    output logic [135:0]  m_tdata,
    output logic          m_tlast
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0]  QFULL = CW'(QUEUE_DEPTH);
    localparam logic [tcu_pkg::RES_NW-1:0] NLIM = tcu_pkg::RES_NW'(tcu_pkg::RESULT_LIMIT);

    tcu_pkg::state_t state_reg, state_next;

    logic [15:0] rto_reg, rto_next;
    logic [31:0] iseq_reg, iseq_next;
    logic [10:0] maxp_reg, maxp_next;
    logic [15:0] cap_reg, cap_next;

    logic [47:0] nseq_reg, nseq_next;
    logic [47:0] ridx_reg, ridx_next;
    logic [16:0] flight_reg, flight_next;
    logic [15:0] wnd_reg, wnd_next;
    logic        syn_sent_reg, syn_sent_next;
    logic        fin_sent_reg, fin_sent_next;
    logic [31:0] tel_reg, tel_next;
    logic [31:0] tlim_reg, tlim_next;
    logic [7:0]  retries_reg, retries_next;
    logic [15:0] buf_reg, buf_next;
    logic        ended_reg, ended_next;
    logic [QAW-1:0] head_reg, head_next;
    logic [QAW-1:0] tail_reg, tail_next;
    logic [CW-1:0]  count_reg, count_next;

    logic [31:0] ack_reg, ack_next;
    logic [15:0] pwin_reg, pwin_next;
    logic [15:0] acc_reg, acc_next;
    logic [48:0] abs_reg, abs_next;
    logic [tcu_pkg::RES_NW-1:0] n_reg, n_next;
    logic [tcu_pkg::RES_AW-1:0] eidx_reg, eidx_next;

    logic           q_we;
    tcu_pkg::qent_t q_wdata, q_rdata;
    tcu_pkg::res_wr_t res_wr;
    tcu_pkg::res_t    res_rdata, seg_out;

    // fill step
    logic [16:0] wnd17, room17, take17;
    logic [10:0] mp11;
    logic        syn_c, fin_c, fill_go;
    logic [11:0] flen;
    logic [15:0] buf_left;
    // ack unwrap
    logic [31:0] aoff;
    logic [48:0] cand, cp49;
    // pop
    logic [11:0] qlen;
    logic [48:0] qend;
    // write action
    logic [15:0] room16, acc16;
    logic [32:0] tsum;
    logic        emit_last;
    logic [2:0]  act;

    assign act = s_tuser;

    assign wnd17   = (wnd_reg == 16'd0) ? 17'd1 : {1'b0, wnd_reg};
    assign mp11    = (maxp_reg > tcu_pkg::PAYLOAD_CEIL) ? tcu_pkg::PAYLOAD_CEIL : maxp_reg;
    assign syn_c   = !syn_sent_reg;
    assign fill_go = (wnd17 > flight_reg) && (count_reg != QFULL) && (n_reg != NLIM);
    assign room17  = wnd17 - flight_reg - {16'd0, syn_c};

    always_comb begin
        take17 = room17;
        if (take17 > {6'd0, mp11}) begin
            take17 = {6'd0, mp11};
        end
        if (take17 > {1'b0, buf_reg}) begin
            take17 = {1'b0, buf_reg};
        end
    end

    assign buf_left = buf_reg - take17[15:0];
    assign fin_c = !fin_sent_reg && ended_reg && (buf_left == 16'd0)
                   && ({1'b0, wnd17} > ({1'b0, take17} + {1'b0, flight_reg}));
    assign flen = {11'd0, syn_c} + {1'b0, take17[10:0]} + {11'd0, fin_c};

    assign aoff = ack_reg - iseq_reg;
    assign cand = {1'b0, nseq_reg[47:32], aoff};
    assign cp49 = {1'b0, nseq_reg};

    assign qlen = {1'b0, q_rdata.len} + {11'd0, q_rdata.syn} + {11'd0, q_rdata.fin};
    assign qend = {1'b0, q_rdata.start} + {37'd0, qlen};

    assign room16 = cap_reg - buf_reg;
    assign acc16  = (s_tdata[15:0] < room16) ? s_tdata[15:0] : room16;
    assign tsum   = {1'b0, tel_reg} + {1'b0, s_tdata[95:64]};

    assign emit_last = (n_reg == '0) || ({1'b0, eidx_reg} == (n_reg - 1'b1));

    always_comb begin
        state_next    = state_reg;
        rto_next      = rto_reg;
        iseq_next     = iseq_reg;
        maxp_next     = maxp_reg;
        cap_next      = cap_reg;
        nseq_next     = nseq_reg;
        ridx_next     = ridx_reg;
        flight_next   = flight_reg;
        wnd_next      = wnd_reg;
        syn_sent_next = syn_sent_reg;
        fin_sent_next = fin_sent_reg;
        tel_next      = tel_reg;
        tlim_next     = tlim_reg;
        retries_next  = retries_reg;
        buf_next      = buf_reg;
        ended_next    = ended_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        ack_next      = ack_reg;
        pwin_next     = pwin_reg;
        acc_next      = acc_reg;
        abs_next      = abs_reg;
        n_next        = n_reg;
        eidx_next     = eidx_reg;
        q_we          = 1'b0;
        q_wdata       = '{start: nseq_reg, len: take17[10:0], syn: syn_c, fin: fin_c};
        res_wr.we     = 1'b0;
        res_wr.waddr  = n_reg[tcu_pkg::RES_AW-1:0];
        res_wr.wdata  = '{seqno: iseq_reg + nseq_reg[31:0], syn: syn_c, fin: fin_c,
                          offset: ridx_reg, len: take17[10:0], rexmit: 1'b0};

        if (cfg_we) begin
            case (cfg_addr)
                tcu_pkg::CFG_RTO:  rto_next  = cfg_wdata[15:0];
                tcu_pkg::CFG_ISEQ: iseq_next = cfg_wdata;
                tcu_pkg::CFG_MAXP: maxp_next = cfg_wdata[10:0];
                tcu_pkg::CFG_CAP:  cap_next  = cfg_wdata[15:0];
                default: ;
            endcase
        end

        case (state_reg)
            tcu_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    ack_next  = s_tdata[47:16];
                    pwin_next = s_tdata[63:48];
                    acc_next  = 16'd0;
                    n_next    = '0;
                    eidx_next = '0;
                    case (act)
                        tcu_pkg::ACT_WRITE: begin
                            if (!ended_reg && (buf_reg < cap_reg)) begin
                                acc_next = acc16;
                                buf_next = buf_reg + acc16;
                            end
                            state_next = tcu_pkg::S_FILL;
                        end
                        tcu_pkg::ACT_END: begin
                            ended_next = 1'b1;
                            state_next = tcu_pkg::S_FILL;
                        end
                        tcu_pkg::ACT_ACK: begin
                            state_next = tcu_pkg::S_ACKCHK;
                        end
                        tcu_pkg::ACT_TICK: begin
                            tel_next   = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
                            state_next = tcu_pkg::S_TICKCHK;
                        end
                        tcu_pkg::ACT_EMPTY: begin
                            res_wr.we    = 1'b1;
                            res_wr.waddr = '0;
                            res_wr.wdata = '{seqno: iseq_reg + nseq_reg[31:0], syn: 1'b0,
                                             fin: 1'b0, offset: ridx_reg, len: 11'd0,
                                             rexmit: 1'b0};
                            n_next       = tcu_pkg::RES_NW'(1);
                            state_next   = tcu_pkg::S_EMIT;
                        end
                        default: begin
                            state_next = tcu_pkg::S_EMIT;
                        end
                    endcase
                end
            end
            tcu_pkg::S_ACKCHK: begin
                if ((cand > (cp49 + 49'h0_8000_0000)) && (cand[48:32] != 17'd0)) begin
                    abs_next = cand - 49'h1_0000_0000;
                end else if ((cand + 49'h0_8000_0000) < cp49) begin
                    abs_next = cand + 49'h1_0000_0000;
                end else begin
                    abs_next = cand;
                end
                state_next = tcu_pkg::S_ACKCMP;
            end
            tcu_pkg::S_ACKCMP: begin
                if (abs_reg <= cp49) begin
                    wnd_next   = pwin_reg;
                    state_next = (count_reg != '0) ? tcu_pkg::S_POPCHK : tcu_pkg::S_FILL;
                end else begin
                    state_next = tcu_pkg::S_EMIT;
                end
            end
            tcu_pkg::S_POPCHK: begin
                // q_rdata holds the head entry, read through the registered queue memory port
                if (qend > abs_reg) begin
                    state_next = tcu_pkg::S_FILL;
                end else begin
                    flight_next  = flight_reg - {5'd0, qlen};
                    head_next    = (head_reg == QLAST) ? '0 : head_reg + 1'b1;
                    count_next   = count_reg - 1'b1;
                    tlim_next    = {16'd0, rto_reg};
                    tel_next     = 32'd0;
                    retries_next = 8'd0;
                    if (count_reg == CW'(1)) begin
                        state_next = tcu_pkg::S_FILL;
                    end
                end
            end
            tcu_pkg::S_FILL: begin
                if (!fill_go) begin
                    state_next = tcu_pkg::S_EMIT;
                end else begin
                    syn_sent_next = 1'b1;
                    buf_next      = buf_left;
                    ridx_next     = ridx_reg + {37'd0, take17[10:0]};
                    if (fin_c) begin
                        fin_sent_next = 1'b1;
                    end
                    if (flen == 12'd0) begin
                        state_next = tcu_pkg::S_EMIT;
                    end else begin
                        if (count_reg == '0) begin
                            tlim_next = {16'd0, rto_reg};
                            tel_next  = 32'd0;
                        end
                        q_we        = 1'b1;
                        tail_next   = (tail_reg == QLAST) ? '0 : tail_reg + 1'b1;
                        count_next  = count_reg + 1'b1;
                        res_wr.we   = 1'b1;
                        n_next      = n_reg + 1'b1;
                        nseq_next   = nseq_reg + {36'd0, flen};
                        flight_next = flight_reg + {5'd0, flen};
                        if (fin_c) begin
                            state_next = tcu_pkg::S_EMIT;
                        end
                    end
                end
            end
            tcu_pkg::S_TICKCHK: begin
                if ((count_reg != '0) && (tel_reg >= tlim_reg)) begin
                    if (wnd_reg != 16'd0) begin
                        tlim_next = tlim_reg[31] ? 32'hFFFF_FFFF : {tlim_reg[30:0], 1'b0};
                    end
                    tel_next     = 32'd0;
                    res_wr.we    = 1'b1;
                    res_wr.waddr = '0;
                    res_wr.wdata = '{seqno: iseq_reg + q_rdata.start[31:0], syn: q_rdata.syn,
                                     fin: q_rdata.fin,
                                     offset: q_rdata.start + {47'd0, q_rdata.syn} - 48'd1,
                                     len: q_rdata.len, rexmit: 1'b1};
                    n_next       = tcu_pkg::RES_NW'(1);
                    if (retries_reg != 8'hFF) begin
                        retries_next = retries_reg + 1'b1;
                    end
                end
                state_next = tcu_pkg::S_EMIT;
            end
            tcu_pkg::S_EMIT: begin
                if (m_tready) begin
                    if (emit_last) begin
                        state_next = tcu_pkg::S_IDLE;
                    end else begin
                        eidx_next = eidx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = tcu_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tcu_pkg::S_IDLE;
            rto_reg      <= 16'd1000;
            iseq_reg     <= 32'd0;
            maxp_reg     <= 11'd1000;
            cap_reg      <= 16'hFFFF;
            nseq_reg     <= 48'd0;
            ridx_reg     <= 48'd0;
            flight_reg   <= 17'd0;
            wnd_reg      <= 16'd1;
            syn_sent_reg <= 1'b0;
            fin_sent_reg <= 1'b0;
            tel_reg      <= 32'd0;
            tlim_reg     <= 32'd1000;
            retries_reg  <= 8'd0;
            buf_reg      <= 16'd0;
            ended_reg    <= 1'b0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            n_reg        <= '0;
            eidx_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            rto_reg      <= rto_next;
            iseq_reg     <= iseq_next;
            maxp_reg     <= maxp_next;
            cap_reg      <= cap_next;
            nseq_reg     <= nseq_next;
            ridx_reg     <= ridx_next;
            flight_reg   <= flight_next;
            wnd_reg      <= wnd_next;
            syn_sent_reg <= syn_sent_next;
            fin_sent_reg <= fin_sent_next;
            tel_reg      <= tel_next;
            tlim_reg     <= tlim_next;
            retries_reg  <= retries_next;
            buf_reg      <= buf_next;
            ended_reg    <= ended_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            n_reg        <= n_next;
            eidx_reg     <= eidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        ack_reg  <= ack_next;
        pwin_reg <= pwin_next;
        acc_reg  <= acc_next;
        abs_reg  <= abs_next;
    end

    // head is always read ahead through head_next, so the registered read holds the head entry
    tcu_queue_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (QAW)
    ) u_queue (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (q_wdata),
        .raddr (head_next),
        .rdata (q_rdata)
    );

    tcu_result_buf u_results (
        .aclk  (aclk),
        .wr    (res_wr),
        .raddr (eidx_next),
        .rdata (res_rdata)
    );

    assign seg_out  = (n_reg != '0) ? res_rdata : '0;
    assign s_tready = (state_reg == tcu_pkg::S_IDLE);
    assign m_tvalid = (state_reg == tcu_pkg::S_EMIT);
    assign m_tlast  = emit_last;
    assign m_tdata  = {acc_reg, retries_reg, flight_reg, seg_out.rexmit, seg_out.len,
                       seg_out.offset, seg_out.fin, seg_out.syn, seg_out.seqno,
                       (n_reg != '0)};

    `TCU_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= QFULL, "queue count above depth")
    `TCU_ASSERT_IMP(a_flight_empty, count_reg == '0, flight_reg == 17'd0, "flight with empty queue")
    `TCU_ASSERT_IMP(a_fin_after_end, fin_sent_reg, ended_reg, "fin sent before input end")
    `TCU_ASSERT_IMP(a_no_take_emit, m_tvalid, !s_tready, "input taken while results pending")
    `TCU_ASSERT_NXT(a_res_count, res_wr.we, n_reg != '0, "result written but not counted")

endmodule

>>> src/tcu_queue_mem.sv
// ---------------------------------------------------------------------------
// tcu_queue_mem
// outstanding segment store, one write and one registered read port
// ---------------------------------------------------------------------------
module tcu_queue_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  tcu_pkg::qent_t  wdata,
    input  logic [AW-1:0]   raddr,
    output tcu_pkg::qent_t  rdata
);

    tcu_pkg::qent_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read returns old data on a same-address write; control never uses it then
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> src/tcu_result_buf.sv
// ---------------------------------------------------------------------------
// tcu_result_buf
// holds the segment descriptors of one item until they are sent out
// ---------------------------------------------------------------------------
module tcu_result_buf (
    input  logic                       aclk,
    input  tcu_pkg::res_wr_t           wr,
    input  logic [tcu_pkg::RES_AW-1:0] raddr,
    output tcu_pkg::res_t              rdata
);

    tcu_pkg::res_t mem [tcu_pkg::RESULT_LIMIT];

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.waddr] <= wr.wdata;
        end
    end

    // forward a write to the entry being read
    always_ff @(posedge aclk) begin
        if (wr.we && (wr.waddr == raddr)) begin
            rdata <= wr.wdata;
        end else begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench for tcp_transmit_control_unit
// Drives write, end, ack, tick and empty-segment beats into the sender control
// block, predicts every segment descriptor in a local copy of the sender
// state, and checks each result beat field by field under random gaps and
// back pressure, over several register settings.
// ---------------------------------------------------------------------------
module testbench;

    localparam int  DEPTH       = 32;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam logic [47:0] SEQ_MASK = 48'hFFFF_FFFF_FFFF;

    // result beat, packed from the top bit down as on m_tdata
    typedef struct packed {
        logic [15:0] accepted;
        logic [7:0]  retry;
        logic [16:0] flight;
        logic        rexmit;
        logic [10:0] len;
        logic [47:0] offset;
        logic        fin;
        logic        syn;
        logic [31:0] seqno;
        logic        seg;
    } seg_beat_t;

    typedef struct {
        seg_beat_t beat;
        bit        last;
    } seg_result_t;

    logic          aclk = 1'b0;
    logic          aresetn;
    logic          cfg_we;
    logic [1:0]    cfg_addr;
    logic [31:0]   cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [95:0]   s_tdata;
    logic [2:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [135:0]  m_tdata;
    logic          m_tlast;

    tcp_transmit_control_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    // sender-side state as predicted
    logic [47:0]  next_seq, read_idx;
    int unsigned  in_flight, wnd_held, tmr_elapsed, tmr_limit, retry_cnt, buffered;
    bit           syn_done, fin_done, input_closed;
    logic [47:0]  seg_start [DEPTH];
    int unsigned  seg_len   [DEPTH];
    bit [1:0]     seg_flags [DEPTH];
    int unsigned  seg_head, seg_count;
    // register copies
    int unsigned  rto_reg, iseq_reg, maxp_reg, cap_reg;

    seg_result_t  expected_segs[$];
    seg_beat_t    item_segs[$];

    int  errors, items_sent, beats_seen, segs_seen, rexmits_seen, cycles;
    bit  rx_hold, quiet;

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        errors++;
        if (errors <= 20)
            $display("mismatch at beat %0d: %s expected %0h got %0h",
                     beats_seen, what, want, got);
    endtask

    task automatic add_segment(input logic [47:0] abs_seq, input bit syn, input bit fin,
                               input logic [47:0] off, input int unsigned len,
                               input bit rexmit);
        seg_beat_t b;
        b = '0;
        b.seg    = 1'b1;
        b.seqno  = iseq_reg + abs_seq[31:0];
        b.syn    = syn;
        b.fin    = fin;
        b.offset = off;
        b.len    = len[10:0];
        b.rexmit = rexmit;
        item_segs.push_back(b);
    endtask

    task automatic fill_window_pred();
        int unsigned wnd, mp, syn, fin, take, len, slot;
        logic [47:0] off;
        wnd = (wnd_held != 0) ? wnd_held : 1;
        mp  = (maxp_reg > tcu_pkg::PAYLOAD_CEIL) ? tcu_pkg::PAYLOAD_CEIL : maxp_reg;
        while (wnd > in_flight && seg_count < DEPTH
               && item_segs.size() < tcu_pkg::RESULT_LIMIT) begin
            syn = syn_done ? 0 : 1;
            fin = 0;
            off = read_idx;
            syn_done = 1'b1;
            take = wnd - in_flight - syn;
            if (take > mp) take = mp;
            if (take > buffered) take = buffered;
            buffered -= take;
            read_idx = (read_idx + take) & SEQ_MASK;
            if (!fin_done && input_closed && buffered == 0 && wnd > take + in_flight) begin
                fin_done = 1'b1;
                fin = 1;
            end
            len = syn + take + fin;
            if (len == 0) return;
            if (seg_count == 0) begin
                tmr_limit = rto_reg;
                tmr_elapsed = 0;
            end
            slot = (seg_head + seg_count) % DEPTH;
            seg_start[slot] = next_seq;
            seg_len[slot]   = take;
            seg_flags[slot] = {fin[0], syn[0]};
            seg_count++;
            add_segment(next_seq, syn[0], fin[0], off, take, 1'b0);
            next_seq = (next_seq + len) & SEQ_MASK;
            in_flight += len;
            if (fin != 0) return;
        end
    endtask

    function automatic longint unsigned unwrap_ackno(input logic [31:0] ack);
        longint unsigned off, cp, cand;
        off  = {32'd0, ack - iseq_reg};
        cp   = {16'd0, next_seq};
        cand = (cp & ~64'hFFFF_FFFF) | off;
        if (cand > cp + 64'h8000_0000 && cand >= 64'h1_0000_0000)
            cand -= 64'h1_0000_0000;
        else if (cand + 64'h8000_0000 < cp)
            cand += 64'h1_0000_0000;
        return cand;
    endfunction

    // works out the result beats of one accepted item and queues them
    task automatic predict_segments(input logic [2:0] act, input logic [15:0] wlen,
                                    input logic [31:0] ack, input logic [15:0] pwin,
                                    input logic [31:0] el);
        int unsigned accepted, len, room;
        longint unsigned abs_ack;
        bit popped;
        seg_result_t r;
        accepted = 0;
        item_segs.delete();
        case (act)
            tcu_pkg::ACT_WRITE: begin
                if (!input_closed && buffered < cap_reg) begin
                    room = cap_reg - buffered;
                    accepted = (wlen < room) ? wlen : room;
                    buffered += accepted;
                end
                fill_window_pred();
            end
            tcu_pkg::ACT_END: begin
                input_closed = 1'b1;
                fill_window_pred();
            end
            tcu_pkg::ACT_ACK: begin
                abs_ack = unwrap_ackno(ack);
                if (abs_ack <= {16'd0, next_seq}) begin
                    popped = 1'b0;
                    while (seg_count > 0) begin
                        len = seg_len[seg_head] + seg_flags[seg_head][0]
                              + seg_flags[seg_head][1];
                        if ({16'd0, seg_start[seg_head]} + len > abs_ack) break;
                        in_flight -= len;
                        seg_head = (seg_head + 1) % DEPTH;
                        seg_count--;
                        tmr_limit = rto_reg;
                        tmr_elapsed = 0;
                        popped = 1'b1;
                    end
                    if (popped) retry_cnt = 0;
                    wnd_held = pwin;
                    fill_window_pred();
                end
            end
            tcu_pkg::ACT_TICK: begin
                tmr_elapsed = (tmr_elapsed > 32'hFFFF_FFFF - el) ? 32'hFFFF_FFFF
                                                                 : tmr_elapsed + el;
                if (seg_count > 0 && tmr_elapsed >= tmr_limit) begin
                    if (wnd_held > 0)
                        tmr_limit = (tmr_limit > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF
                                                                : tmr_limit * 2;
                    tmr_elapsed = 0;
                    add_segment(seg_start[seg_head], seg_flags[seg_head][0],
                                seg_flags[seg_head][1],
                                (seg_start[seg_head] + seg_flags[seg_head][0] - 1) & SEQ_MASK,
                                seg_len[seg_head], 1'b1);
                    if (retry_cnt < 255) retry_cnt++;
                end
            end
            tcu_pkg::ACT_EMPTY: add_segment(next_seq, 1'b0, 1'b0, read_idx, 0, 1'b0);
            default: ;
        endcase
        if (item_segs.size() == 0) item_segs.push_back('0);
        foreach (item_segs[k]) begin
            r.beat          = item_segs[k];
            r.beat.flight   = in_flight[16:0];
            r.beat.retry    = retry_cnt[7:0];
            r.beat.accepted = accepted[15:0];
            r.last          = (k == item_segs.size() - 1);
            expected_segs.push_back(r);
        end
    endtask

    function automatic int gap_cycles();
        int p;
        if (quiet) return 0;
        p = $urandom_range(0, 99);
        if (p < 70) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic [2:0] act, input logic [15:0] wlen,
                             input logic [31:0] ack, input logic [15:0] pwin,
                             input logic [31:0] el);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {el, pwin, ack, wlen};
        do @(posedge aclk); while (!s_tready);
        predict_segments(act, wlen, ack, pwin, el);
        items_sent++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        release_input();
        while (expected_segs.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            tcu_pkg::CFG_RTO:  rto_reg  = value[15:0];
            tcu_pkg::CFG_ISEQ: iseq_reg = value;
            tcu_pkg::CFG_MAXP: maxp_reg = value[10:0];
            default:           cap_reg  = value[15:0];
        endcase
    endtask

    task automatic set_registers(input logic [31:0] rto, input logic [31:0] iseq,
                                 input logic [31:0] maxp, input logic [31:0] cap);
        wait_drained();
        write_reg(tcu_pkg::CFG_RTO, rto);
        write_reg(tcu_pkg::CFG_ISEQ, iseq);
        write_reg(tcu_pkg::CFG_MAXP, maxp);
        write_reg(tcu_pkg::CFG_CAP, cap);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // ack number somewhere inside what is in flight, mostly all of it
    function automatic logic [31:0] ack_in_flight(input bit whole);
        logic [47:0] abs_seq;
        abs_seq = next_seq;
        if (!whole && in_flight > 0) abs_seq = next_seq - $urandom_range(0, in_flight);
        return iseq_reg + abs_seq[31:0];
    endfunction

    function automatic logic [15:0] pick_window();
        int p;
        p = $urandom_range(0, 99);
        if (p < 8)  return 16'd0;
        if (p < 20) return 16'($urandom_range(1, 100));
        if (p < 30) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(2000, 65535));
    endfunction

    task automatic test_directed();
        send_item(tcu_pkg::ACT_EMPTY, 16'd0, 32'd0, 16'd0, 32'd0);
        send_item(tcu_pkg::ACT_WRITE, 16'd0, 32'd0, 16'd0, 32'd0);     // syn only, window of one
        send_item(tcu_pkg::ACT_WRITE, 16'd5000, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(tcu_pkg::ACT_ACK, 16'd0, iseq_reg + 32'd7, 16'd3000, 32'd0);  // beyond next
        send_item(tcu_pkg::ACT_ACK, 16'd0, iseq_reg, 16'd3000, 32'd0); // covers nothing new
        send_item(tcu_pkg::ACT_TICK, 16'd0, 32'd0, 16'd0, 32'd999);
        send_item(tcu_pkg::ACT_TICK, 16'd0, 32'd0, 16'd0, 32'd1);      // expiry
        send_item(tcu_pkg::ACT_TICK, 16'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);  // elapsed reaches its maximum
        send_item(tcu_pkg::ACT_ACK, 16'd0, ack_in_flight(1'b1), 16'd0, 32'd0);  // zero window
        send_item(tcu_pkg::ACT_TICK, 16'd0, 32'd0, 16'd0, 32'hFFFF_FFFF);  // no doubling
        send_item(3'd5, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(3'd6, 16'd1, 32'd1, 16'd1, 32'd1);
        send_item(3'd7, 16'd0, 32'd0, 16'd0, 32'd0);
        send_item(tcu_pkg::ACT_WRITE, 16'hFFFF, 32'd0, 16'd0, 32'd0);  // buffer fills up
        send_item(tcu_pkg::ACT_ACK, 16'd0, ack_in_flight(1'b1), 16'hFFFF, 32'd0);  // full fill
        send_item(tcu_pkg::ACT_ACK, 16'd0, ack_in_flight(1'b0), 16'hFFFF, 32'd0);
        send_item(tcu_pkg::ACT_EMPTY, 16'd0, 32'd0, 16'd0, 32'd0);
    endtask

    task automatic test_random(input int count);
        int p;
        repeat (count) begin
            p = $urandom_range(0, 99);
            if (p < 35)
                send_item(tcu_pkg::ACT_WRITE, ($urandom_range(0, 19) == 0) ? 16'hFFFF
                          : 16'($urandom_range(0, 3000)), $urandom, 16'($urandom), $urandom);
            else if (p < 63)
                send_item(tcu_pkg::ACT_ACK, 16'($urandom),
                          ack_in_flight(1'($urandom_range(0, 1))), pick_window(), $urandom);
            else if (p < 68)
                send_item(tcu_pkg::ACT_ACK, 16'($urandom), $urandom, pick_window(), $urandom);
            else if (p < 90)
                send_item(tcu_pkg::ACT_TICK, 16'($urandom), $urandom, 16'($urandom),
                          ($urandom_range(0, 9) == 0) ? $urandom
                          : 32'($urandom_range(0, 2 * tmr_limit + 2)));
            else if (p < 96)
                send_item(tcu_pkg::ACT_EMPTY, 16'($urandom), $urandom, 16'($urandom), $urandom);
            else
                send_item(3'($urandom_range(5, 7)), 16'($urandom), $urandom, 16'($urandom),
                          $urandom);
        end
    endtask

    // receiver holds off for a long stretch while writes keep coming
    task automatic test_backpressure();
        send_item(tcu_pkg::ACT_ACK, 16'd0, ack_in_flight(1'b1), 16'hFFFF, 32'd0);
        fork
            begin
                @(negedge aclk);
                rx_hold = 1'b1;
                repeat (600) @(negedge aclk);
                rx_hold = 1'b0;
            end
            begin
                repeat (12) begin
                    send_item(tcu_pkg::ACT_WRITE, 16'd4000, 32'd0, 16'd0, 32'd0);
                    send_item(tcu_pkg::ACT_ACK, 16'd0, ack_in_flight(1'b1), 16'hFFFF, 32'd0);
                end
            end
        join
    endtask

    // zero timeout: every tick resends while segments wait
    task automatic test_zero_timeout();
        send_item(tcu_pkg::ACT_WRITE, 16'd3000, 32'd0, 16'd0, 32'd0);
        send_item(tcu_pkg::ACT_ACK, 16'd0, ack_in_flight(1'b1), 16'd2000, 32'd0);
        repeat (4) send_item(tcu_pkg::ACT_TICK, 16'd0, 32'd0, 16'd0, 32'd0);
        repeat (260) send_item(tcu_pkg::ACT_TICK, 16'd0, 32'd0, 16'd5, 32'd0);  // retries saturate
    endtask

    task automatic test_close();
        send_item(tcu_pkg::ACT_WRITE, 16'd2500, 32'd0, 16'd0, 32'd0);
        send_item(tcu_pkg::ACT_END, 16'd0, 32'd0, 16'd0, 32'd0);
        send_item(tcu_pkg::ACT_WRITE, 16'd100, 32'd0, 16'd0, 32'd0);  // after end, nothing taken
        repeat (8) begin
            send_item(tcu_pkg::ACT_ACK, 16'd0, ack_in_flight(1'b1), 16'hFFFF, 32'd0);
            send_item(tcu_pkg::ACT_TICK, 16'd0, 32'd0, 16'd0, $urandom_range(0, 3000));
        end
        send_item(tcu_pkg::ACT_END, 16'd0, 32'd0, 16'd0, 32'd0);
        send_item(tcu_pkg::ACT_EMPTY, 16'd0, 32'd0, 16'd0, 32'd0);
        test_random(10);
    endtask

    // result side: random stalls, a long hold when asked
    int stall_left;
    always @(negedge aclk) begin
        if (!aresetn || rx_hold) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 15) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        seg_beat_t   got;
        seg_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            beats_seen++;
            if (expected_segs.size() == 0) begin
                report_mismatch("unexpected beat", 64'd0, 64'd1);
            end else begin
                want = expected_segs.pop_front();
                if (got.seg      !== want.beat.seg)      report_mismatch("seg_valid", want.beat.seg, got.seg);
                if (got.seqno    !== want.beat.seqno)    report_mismatch("seg_seqno", want.beat.seqno, got.seqno);
                if (got.syn      !== want.beat.syn)      report_mismatch("seg_syn", want.beat.syn, got.syn);
                if (got.fin      !== want.beat.fin)      report_mismatch("seg_fin", want.beat.fin, got.fin);
                if (got.offset   !== want.beat.offset)   report_mismatch("payload_offset", want.beat.offset, got.offset);
                if (got.len      !== want.beat.len)      report_mismatch("payload_len", want.beat.len, got.len);
                if (got.rexmit   !== want.beat.rexmit)   report_mismatch("is_retransmit", want.beat.rexmit, got.rexmit);
                if (got.flight   !== want.beat.flight)   report_mismatch("flight_bytes", want.beat.flight, got.flight);
                if (got.retry    !== want.beat.retry)    report_mismatch("retry_count", want.beat.retry, got.retry);
                if (got.accepted !== want.beat.accepted) report_mismatch("accepted_len", want.beat.accepted, got.accepted);
                if (m_tlast      !== want.last)          report_mismatch("tlast", want.last, m_tlast);
                if (want.beat.seg)    segs_seen++;
                if (want.beat.rexmit) rexmits_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected",
                     cycles, expected_segs.size());
            $display("** tcp_transmit_control_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        m_tready = 1'b0;
        rx_hold = 1'b0; quiet = 1'b0; stall_left = 0;
        errors = 0; items_sent = 0; beats_seen = 0; segs_seen = 0;
        rexmits_seen = 0; cycles = 0;
        rto_reg = 1000; iseq_reg = 0; maxp_reg = 1000; cap_reg = 65535;
        next_seq = '0; read_idx = '0; in_flight = 0; wnd_held = 1;
        tmr_elapsed = 0; tmr_limit = 1000; retry_cnt = 0; buffered = 0;
        syn_done = 0; fin_done = 0; input_closed = 0; seg_head = 0; seg_count = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(25);
        set_registers(32'd1, 32'hFFFF_FFFF, 32'h7FF, 32'd1);     // capacity below buffer
        test_random(20);
        quiet = 1'b1;
        set_registers(32'd65535, $urandom, 32'd0, 32'd65535);    // no payload
        test_random(10);
        quiet = 1'b0;
        set_registers(32'd0, 32'd0, 32'd1452, 32'd65535);
        test_zero_timeout();
        set_registers(32'($urandom_range(1, 65535)), $urandom,
                      32'($urandom_range(1, 1452)), 32'($urandom_range(1, 65535)));
        test_random(20);
        set_registers(32'd1000, 32'h8000_0000, 32'd1000, 32'd65535);
        test_backpressure();
        test_random(15);
        test_close();

        wait_drained();
        $display("%0d items sent, %0d result beats checked (%0d segments, %0d resends)",
                 items_sent, beats_seen, segs_seen, rexmits_seen);
        $display("covered window fill and ack pops, timer expiry, register extremes, stalls");
        if (errors == 0)
            $display("** tcp_transmit_control_unit: PASSED **");
        else
            $display("** tcp_transmit_control_unit: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/tcu_pkg.sv
src/tcu_queue_mem.sv
src/tcu_result_buf.sv
src/tcp_transmit_control_unit.sv
tb/testbench.sv
